@@ hw/rtl/cgs_pkg.sv @@
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types, reset values and helpers of the clamp grasp sequencer.
// ----------------------------------------------------------------------------
package cgs_pkg;

	localparam int unsigned DefWindow = 5;

	localparam int unsigned SampleW = 16;
	localparam int unsigned DriveW  = 10;
	localparam int unsigned ScaleW  = 9;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW    = 16;

	localparam logic signed [7:0]  RstActiveMode   = 8'sd3;
	localparam logic signed [15:0] RstForceLimit   = 16'sd800;
	localparam logic [15:0]        RstStretchLimit = 16'd4352;
	localparam logic [8:0]         RstMoveScale    = 9'd128;
	localparam logic [8:0]         RstGripScale    = 9'd128;
	localparam logic [15:0]        RstTimeout      = 16'd30;
	localparam logic [8:0]         ScaleMax        = 9'd256;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ACTIVE_MODE    = 3'd0,
		REG_FORCE_LIMIT    = 3'd1,
		REG_STRETCH_LIMIT  = 3'd2,
		REG_MOVEMENT_SCALE = 3'd3,
		REG_GRIP_SCALE     = 3'd4,
		REG_TIMEOUT_TICKS  = 3'd5
	} cgs_reg_t;

	typedef enum logic [2:0] {
		PH_LOWER = 3'd0,
		PH_OPEN  = 3'd1,
		PH_WAIT  = 3'd2,
		PH_CLOSE = 3'd3,
		PH_RAISE = 3'd4,
		PH_DONE  = 3'd5
	} cgs_phase_t;

	typedef struct packed {
		logic signed [7:0]  ctrl_mode;
		logic               at_top;
		logic               at_bottom;
		logic               fully_open;
		logic               fully_closed;
		logic               plate_switch;
		logic signed [15:0] force_reading;
		logic               stretch_valid;
		logic [15:0]        stretch_sample;
		logic               joy_valid;
		logic               manual_button;
		logic               auto_button;
	} cgs_item_t;

	typedef struct packed {
		logic manual_live;
		logic auto_live;
	} cgs_gate_t;

	typedef struct packed {
		logic signed [DriveW-1:0] lift_cmd;
		logic signed [DriveW-1:0] grip_cmd;
		logic                     cmd_sent;
		logic                     plate_seen;
		logic                     grasp_ok;
		logic                     grasp_report;
		logic                     finished;
		logic [2:0]               phase;
	} cgs_result_t;

	function automatic logic [ScaleW-1:0] clip_scale(input logic [ScaleW-1:0] s);
		return (s > ScaleMax) ? ScaleMax : s;
	endfunction

endpackage

@@ hw/rtl/cgs_stretch_window.sv @@
// ----------------------------------------------------------------------------
// cgs_stretch_window
// Running stretch window: sample store, sum and fill, threshold compare.
// ----------------------------------------------------------------------------
module cgs_stretch_window import cgs_pkg::*; #(
	parameter int unsigned WINDOW = DefWindow
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  logic [SampleW-1:0] sample,
	input  logic [15:0]        stretch_limit,
	output logic               above
);

	localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned FILL_W = $clog2(WINDOW + 1);
	localparam int unsigned SUM_W  = SampleW + FILL_W;

	logic [SampleW-1:0] win_q [WINDOW];
	logic [SUM_W-1:0]   sum_q;
	logic [FILL_W-1:0]  fill_q;
	logic [POS_W-1:0]   pos_q;

	logic               full;
	logic [SUM_W-1:0]   sum_nx;
	logic [FILL_W-1:0]  fill_nx;
	logic [POS_W-1:0]   pos_nx;
	logic [SUM_W-1:0]   limit_prod;

	assign full = (fill_q == FILL_W'(WINDOW));

	always_comb begin
		sum_nx  = sum_q;
		fill_nx = fill_q;
		pos_nx  = pos_q;
		if (upd) begin
			sum_nx = sum_q - (full ? SUM_W'(win_q[pos_q]) : '0) + SUM_W'(sample);
			if (!full)
				fill_nx = fill_q + 1'b1;
			pos_nx = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
		end
	end

	// average above limit as sum > limit * count
	assign limit_prod = SUM_W'(stretch_limit) * SUM_W'(fill_nx);
	assign above      = (sum_nx > limit_prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fill_q <= '0;
			pos_q  <= '0;
		end else begin
			sum_q  <= sum_nx;
			fill_q <= fill_nx;
			pos_q  <= pos_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (upd)
			win_q[pos_q] <= sample;
	end

endmodule

@@ hw/rtl/cgs_deadman.sv @@
// ----------------------------------------------------------------------------
// cgs_deadman
// Deadman button state and joystick idle timer.
// ----------------------------------------------------------------------------
module cgs_deadman import cgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        joy_valid,
	input  logic        manual_button,
	input  logic        auto_button,
	input  logic [15:0] timeout_ticks,
	output cgs_gate_t   gate
);

	logic        manual_q, auto_q;
	logic [15:0] idle_q;
	logic        manual_nx, auto_nx;
	logic [15:0] idle_nx;
	logic        live;

	always_comb begin
		manual_nx = manual_q;
		auto_nx   = auto_q;
		idle_nx   = idle_q;
		if (step) begin
			if (joy_valid) begin
				idle_nx   = '0;
				manual_nx = manual_button;
				auto_nx   = auto_button;
			end else if (idle_q != 16'hFFFF) begin
				idle_nx = idle_q + 16'd1;
			end
		end
	end

	assign live             = (idle_nx < timeout_ticks);
	assign gate.manual_live = manual_nx && live;
	assign gate.auto_live   = auto_nx && live;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_q <= 1'b0;
			auto_q   <= 1'b0;
			idle_q   <= '0;
		end else begin
			manual_q <= manual_nx;
			auto_q   <= auto_nx;
			idle_q   <= idle_nx;
		end
	end

endmodule

@@ hw/rtl/cgs_grasp_step.sv @@
// ----------------------------------------------------------------------------
// cgs_grasp_step
// Six-phase grasp sequence with stored drives; forms the gated result.
// ----------------------------------------------------------------------------
module cgs_grasp_step import cgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               at_top,
	input  logic               at_bottom,
	input  logic               fully_open,
	input  logic               fully_closed,
	input  logic signed [15:0] force_reading,
	input  logic               plate,
	input  logic signed [15:0] force_limit,
	input  logic [ScaleW-1:0]  movement_scale,
	input  logic [ScaleW-1:0]  grip_scale,
	input  cgs_gate_t          gate,
	output cgs_result_t        result
);

	cgs_phase_t               phase_q, ph;
	logic signed [DriveW-1:0] lift_q, grip_q, lift, grip;
	logic                     grasp_q, flag, report, firm;
	logic signed [DriveW-1:0] mv, gp;

	assign mv   = $signed({1'b0, clip_scale(movement_scale)});
	assign gp   = $signed({1'b0, clip_scale(grip_scale)});
	assign firm = (force_reading >= force_limit);

	always_comb begin
		ph     = phase_q;
		lift   = lift_q;
		grip   = grip_q;
		flag   = grasp_q;
		report = 1'b0;
		if (ph == PH_LOWER) begin
			if (!at_bottom) begin
				lift = mv;
			end else begin
				lift = '0;
				ph   = PH_OPEN;
			end
		end
		if (ph == PH_OPEN) begin
			if (!fully_open) begin
				grip = gp;
			end else begin
				grip = '0;
				ph   = PH_WAIT;
			end
		end
		if (ph == PH_WAIT) begin
			if (plate)
				ph = PH_CLOSE;
		end
		if (ph == PH_CLOSE) begin
			if (plate && (firm || fully_closed)) begin
				flag   = 1'b1;
				report = 1'b1;
				ph     = PH_RAISE;
			end else if (!plate && fully_closed && !firm) begin
				flag   = 1'b0;
				report = 1'b1;
				ph     = PH_OPEN;
			end
			grip = (!fully_closed && !firm) ? -gp : '0;
		end
		if (ph == PH_RAISE) begin
			if (!at_top) begin
				lift = -mv;
			end else begin
				lift = '0;
				ph   = PH_DONE;
			end
		end
	end

	always_comb begin
		result.lift_cmd     = '0;
		result.grip_cmd     = '0;
		result.cmd_sent     = !gate.manual_live;
		if (!gate.manual_live && gate.auto_live) begin
			result.lift_cmd = lift;
			result.grip_cmd = grip;
		end
		result.plate_seen   = plate;
		result.grasp_ok     = flag;
		result.grasp_report = report;
		result.finished     = (ph == PH_DONE);
		result.phase        = ph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOWER;
			lift_q  <= '0;
			grip_q  <= '0;
			grasp_q <= 1'b0;
		end else if (step) begin
			phase_q <= ph;
			lift_q  <= lift;
			grip_q  <= grip;
			grasp_q <= flag;
		end
	end

endmodule

@@ hw/rtl/clamp_grasp_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// clamp_grasp_sequencer_core
// Grasp sequencer for a plate clamp, stepped once per control tick request.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   tick: mode, switches, force, stretch, joystick
//   out      out_valid / out_ready lift/grip drives, flags, phase
//   cfg      cfg_wr_en             cfg_index, cfg_data
//
// A tick request is stepped while it sits in the input register; a request in
// the active mode has its result land in the output register at the next edge,
// raising out_valid, one request per cycle unless the output stalls. Deadman,
// window sum (valid samples) and phase state (active mode) update in that step.
// Reset clears all state but the sample store, input item and result data; no
// clearing pass. A stalled output holds the step stage; the input register
// takes a new request whenever the step stage moves on or is empty.
// ----------------------------------------------------------------------------
module clamp_grasp_sequencer_core import cgs_pkg::*; #(
	parameter int unsigned WINDOW = DefWindow
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgW-1:0]          cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [7:0]        ctrl_mode,
	input  logic                     at_top,
	input  logic                     at_bottom,
	input  logic                     fully_open,
	input  logic                     fully_closed,
	input  logic                     plate_switch,
	input  logic signed [15:0]       force_reading,
	input  logic                     stretch_valid,
	input  logic [15:0]              stretch_sample,
	input  logic                     joy_valid,
	input  logic                     manual_button,
	input  logic                     auto_button,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DriveW-1:0] lift_cmd,
	output logic signed [DriveW-1:0] grip_cmd,
	output logic                     cmd_sent,
	output logic                     plate_seen,
	output logic                     grasp_ok,
	output logic                     grasp_report,
	output logic                     finished,
	output logic [2:0]               phase
);

	logic signed [7:0]  active_mode_q;
	logic signed [15:0] force_limit_q;
	logic [15:0]        stretch_limit_q;
	logic [ScaleW-1:0]  movement_scale_q;
	logic [ScaleW-1:0]  grip_scale_q;
	logic [15:0]        timeout_q;

	cgs_item_t   item_s1;
	logic        valid_s1;
	cgs_result_t res_q, res_nx;
	logic        out_valid_q;
	logic        adv, step, match, above;
	cgs_gate_t   gate;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_mode_q    <= RstActiveMode;
			force_limit_q    <= RstForceLimit;
			stretch_limit_q  <= RstStretchLimit;
			movement_scale_q <= RstMoveScale;
			grip_scale_q     <= RstGripScale;
			timeout_q        <= RstTimeout;
		end else if (cfg_wr_en) begin
			unique case (cgs_reg_t'(cfg_index))
				REG_ACTIVE_MODE:    active_mode_q    <= $signed(cfg_data[7:0]);
				REG_FORCE_LIMIT:    force_limit_q    <= $signed(cfg_data);
				REG_STRETCH_LIMIT:  stretch_limit_q  <= cfg_data;
				REG_MOVEMENT_SCALE: movement_scale_q <= cfg_data[ScaleW-1:0];
				REG_GRIP_SCALE:     grip_scale_q     <= cfg_data[ScaleW-1:0];
				REG_TIMEOUT_TICKS:  timeout_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid_q || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;
	assign match    = (item_s1.ctrl_mode == active_mode_q);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.ctrl_mode      <= ctrl_mode;
			item_s1.at_top         <= at_top;
			item_s1.at_bottom      <= at_bottom;
			item_s1.fully_open     <= fully_open;
			item_s1.fully_closed   <= fully_closed;
			item_s1.plate_switch   <= plate_switch;
			item_s1.force_reading  <= force_reading;
			item_s1.stretch_valid  <= stretch_valid;
			item_s1.stretch_sample <= stretch_sample;
			item_s1.joy_valid      <= joy_valid;
			item_s1.manual_button  <= manual_button;
			item_s1.auto_button    <= auto_button;
		end
	end

	cgs_stretch_window #(
		.WINDOW(WINDOW)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.upd           (step && item_s1.stretch_valid),
		.sample        (item_s1.stretch_sample),
		.stretch_limit (stretch_limit_q),
		.above         (above)
	);

	cgs_deadman u_deadman (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.joy_valid     (item_s1.joy_valid),
		.manual_button (item_s1.manual_button),
		.auto_button   (item_s1.auto_button),
		.timeout_ticks (timeout_q),
		.gate          (gate)
	);

	cgs_grasp_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step && match),
		.at_top         (item_s1.at_top),
		.at_bottom      (item_s1.at_bottom),
		.fully_open     (item_s1.fully_open),
		.fully_closed   (item_s1.fully_closed),
		.force_reading  (item_s1.force_reading),
		.plate          (above || item_s1.plate_switch),
		.force_limit    (force_limit_q),
		.movement_scale (movement_scale_q),
		.grip_scale     (grip_scale_q),
		.gate           (gate),
		.result         (res_nx)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && match;
		end
	end

	always_ff @(posedge clk) begin
		if (step && match)
			res_q <= res_nx;
	end

	assign out_valid    = out_valid_q;
	assign lift_cmd     = res_q.lift_cmd;
	assign grip_cmd     = res_q.grip_cmd;
	assign cmd_sent     = res_q.cmd_sent;
	assign plate_seen   = res_q.plate_seen;
	assign grasp_ok     = res_q.grasp_ok;
	assign grasp_report = res_q.grasp_report;
	assign finished     = res_q.finished;
	assign phase        = res_q.phase;

endmodule

@@ tb/tb_clamp_grasp_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clamp_grasp_sequencer_core
// Self-checking bench for the clamp grasp sequencer core. A scoreboard class
// keeps its own copy of the sequencer state and register settings, predicts
// the drive result of every accepted tick request in the active mode, and compares
// the results in order. A short directed sequence is followed by random tick phases
// under different register settings and handshake pressure, and a run without
// joystick messages that takes the idle count past the timeout.
// ----------------------------------------------------------------------------
module tb_clamp_grasp_sequencer_core;
	import cgs_pkg::*;

	localparam int CycleLimit = 100000;

	typedef struct packed {
		cgs_phase_t                        ph;
		logic signed [DriveW-1:0]          lift;
		logic signed [DriveW-1:0]          grip;
		logic                              grasp;
		logic [DefWindow-1:0][SampleW-1:0] win;
		logic [31:0]                       wsum;
		logic [31:0]                       wfill;
		logic [31:0]                       wpos;
		logic                              man;
		logic                              aut;
		logic [31:0]                       idle;
	} seq_state_t;

	typedef struct packed {
		logic signed [7:0]  active_mode;
		logic signed [15:0] force_limit;
		logic [15:0]        stretch_limit;
		logic [8:0]         move_scale;
		logic [8:0]         grip_scale;
		logic [15:0]        timeout;
	} seq_cfg_t;

	class grasp_scoreboard;
		seq_state_t  st;
		seq_cfg_t    cfg;
		cgs_result_t due_commands[$];
		int          errors;

		function new();
			st = '0;
			st.ph = PH_LOWER;
			cfg.active_mode = RstActiveMode;
			cfg.force_limit = RstForceLimit;
			cfg.stretch_limit = RstStretchLimit;
			cfg.move_scale = RstMoveScale;
			cfg.grip_scale = RstGripScale;
			cfg.timeout = RstTimeout;
			errors = 0;
		endfunction

		function void load_reg(cgs_reg_t r, logic [CfgW-1:0] d);
			case (r)
				REG_ACTIVE_MODE: cfg.active_mode = d[7:0];
				REG_FORCE_LIMIT: cfg.force_limit = d;
				REG_STRETCH_LIMIT: cfg.stretch_limit = d;
				REG_MOVEMENT_SCALE: cfg.move_scale = d[8:0];
				REG_GRIP_SCALE: cfg.grip_scale = d[8:0];
				REG_TIMEOUT_TICKS: cfg.timeout = d;
				default: ;
			endcase
		endfunction

		function bit plate_now(seq_state_t s, seq_cfg_t c, bit sw);
			return (s.wsum > c.stretch_limit * s.wfill) || sw;
		endfunction

		function bit advance_grasp(inout seq_state_t s, input seq_cfg_t c,
				input cgs_item_t t, output cgs_result_t r);
			int unsigned lift_mag, grip_mag;
			bit firm, plate, report, live, sent;
			logic signed [DriveW-1:0] lift_out, grip_out;
			r = '0;
			if (t.stretch_valid) begin
				if (s.wpos >= DefWindow) s.wpos = 0;
				if (s.wfill >= DefWindow) s.wsum = s.wsum - s.win[s.wpos];
				s.win[s.wpos] = t.stretch_sample;
				s.wsum = s.wsum + t.stretch_sample;
				s.wpos = (s.wpos + 1) % DefWindow;
				if (s.wfill < DefWindow) s.wfill = s.wfill + 1;
			end
			if (t.joy_valid) begin
				s.idle = 0;
				s.man = t.manual_button;
				s.aut = t.auto_button;
			end else if (s.idle < 32'hFFFF) begin
				s.idle = s.idle + 1;
			end
			if (t.ctrl_mode != c.active_mode) return 1'b0;

			lift_mag = (c.move_scale > ScaleMax) ? ScaleMax : c.move_scale;
			grip_mag = (c.grip_scale > ScaleMax) ? ScaleMax : c.grip_scale;
			firm = $signed(t.force_reading) >= $signed(c.force_limit);
			report = 1'b0;
			if (s.ph == PH_LOWER) begin
				if (!t.at_bottom) begin
					s.lift = DriveW'(lift_mag);
				end else begin
					s.lift = '0;
					s.ph = PH_OPEN;
				end
			end
			if (s.ph == PH_OPEN) begin
				if (!t.fully_open) begin
					s.grip = DriveW'(grip_mag);
				end else begin
					s.grip = '0;
					s.ph = PH_WAIT;
				end
			end
			if (s.ph == PH_WAIT && plate_now(s, c, t.plate_switch)) s.ph = PH_CLOSE;
			if (s.ph == PH_CLOSE) begin
				plate = plate_now(s, c, t.plate_switch);
				if (plate && (firm || t.fully_closed)) begin
					s.grasp = 1'b1;
					report = 1'b1;
					s.ph = PH_RAISE;
				end else if (!plate && t.fully_closed && !firm) begin
					s.grasp = 1'b0;
					report = 1'b1;
					s.ph = PH_OPEN;
				end
				s.grip = (!t.fully_closed && !firm) ? -DriveW'(grip_mag) : '0;
			end
			if (s.ph == PH_RAISE) begin
				if (!t.at_top) begin
					s.lift = -DriveW'(lift_mag);
				end else begin
					s.lift = '0;
					s.ph = PH_DONE;
				end
			end

			live = s.idle < c.timeout;
			sent = 1'b1;
			lift_out = '0;
			grip_out = '0;
			if (s.man && live) begin
				sent = 1'b0;
			end else if (s.aut && live) begin
				lift_out = s.lift;
				grip_out = s.grip;
			end
			r.lift_cmd = lift_out;
			r.grip_cmd = grip_out;
			r.cmd_sent = sent;
			r.plate_seen = plate_now(s, c, t.plate_switch);
			r.grasp_ok = s.grasp;
			r.grasp_report = report;
			r.finished = (s.ph == PH_DONE);
			r.phase = s.ph;
			return 1'b1;
		endfunction

		function void note_tick(cgs_item_t t);
			cgs_result_t r;
			if (advance_grasp(st, cfg, t, r)) due_commands = {due_commands, r};
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				if (errors <= 40)
					$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(cgs_result_t got);
			cgs_result_t want;
			if (due_commands.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t result with no request pending: expected none actual phase %0d",
						$time, got.phase);
				return;
			end
			want = due_commands.pop_front();
			compare_field("lift_cmd", int'($signed(want.lift_cmd)), int'($signed(got.lift_cmd)));
			compare_field("grip_cmd", int'($signed(want.grip_cmd)), int'($signed(got.grip_cmd)));
			compare_field("cmd_sent", want.cmd_sent, got.cmd_sent);
			compare_field("plate_seen", want.plate_seen, got.plate_seen);
			compare_field("grasp_ok", want.grasp_ok, got.grasp_ok);
			compare_field("grasp_report", want.grasp_report, got.grasp_report);
			compare_field("finished", want.finished, got.finished);
			compare_field("phase", want.phase, got.phase);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0]       cfg_index = '0;
	logic [CfgW-1:0]          cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [7:0]        ctrl_mode = '0;
	logic                     at_top = 1'b0;
	logic                     at_bottom = 1'b0;
	logic                     fully_open = 1'b0;
	logic                     fully_closed = 1'b0;
	logic                     plate_switch = 1'b0;
	logic signed [15:0]       force_reading = '0;
	logic                     stretch_valid = 1'b0;
	logic [15:0]              stretch_sample = '0;
	logic                     joy_valid = 1'b0;
	logic                     manual_button = 1'b0;
	logic                     auto_button = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DriveW-1:0] lift_cmd;
	logic signed [DriveW-1:0] grip_cmd;
	logic                     cmd_sent;
	logic                     plate_seen;
	logic                     grasp_ok;
	logic                     grasp_report;
	logic                     finished;
	logic [2:0]               phase;

	grasp_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	clamp_grasp_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ctrl_mode(ctrl_mode),
		.at_top(at_top),
		.at_bottom(at_bottom),
		.fully_open(fully_open),
		.fully_closed(fully_closed),
		.plate_switch(plate_switch),
		.force_reading(force_reading),
		.stretch_valid(stretch_valid),
		.stretch_sample(stretch_sample),
		.joy_valid(joy_valid),
		.manual_button(manual_button),
		.auto_button(auto_button),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lift_cmd(lift_cmd),
		.grip_cmd(grip_cmd),
		.cmd_sent(cmd_sent),
		.plate_seen(plate_seen),
		.grasp_ok(grasp_ok),
		.grasp_report(grasp_report),
		.finished(finished),
		.phase(phase)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cgs_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.lift_cmd = lift_cmd;
			got.grip_cmd = grip_cmd;
			got.cmd_sent = cmd_sent;
			got.plate_seen = plate_seen;
			got.grasp_ok = grasp_ok;
			got.grasp_report = grasp_report;
			got.finished = finished;
			got.phase = phase;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic set_reg(input cgs_reg_t r, input int v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= CfgW'(v);
		sb.load_reg(r, CfgW'(v));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic program_regs(input int am, input int fl, input int sl, input int ms,
			input int gs, input int to);
		set_reg(REG_ACTIVE_MODE, am);
		set_reg(REG_FORCE_LIMIT, fl);
		set_reg(REG_STRETCH_LIMIT, sl);
		set_reg(REG_MOVEMENT_SCALE, ms);
		set_reg(REG_GRIP_SCALE, gs);
		set_reg(REG_TIMEOUT_TICKS, to);
	endtask

	task automatic settle();
		while (sb.due_commands.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_tick(input cgs_item_t t);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		ctrl_mode <= t.ctrl_mode;
		at_top <= t.at_top;
		at_bottom <= t.at_bottom;
		fully_open <= t.fully_open;
		fully_closed <= t.fully_closed;
		plate_switch <= t.plate_switch;
		force_reading <= t.force_reading;
		stretch_valid <= t.stretch_valid;
		stretch_sample <= t.stretch_sample;
		joy_valid <= t.joy_valid;
		manual_button <= t.manual_button;
		auto_button <= t.auto_button;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(t);
	endtask

	function automatic cgs_item_t tick_of(input int mode, input logic [4:0] sw, input int frc,
			input bit sv, input int smp, input bit jv, input bit man, input bit aut);
		cgs_item_t t;
		t.ctrl_mode = 8'(mode);
		{t.at_top, t.at_bottom, t.fully_open, t.fully_closed, t.plate_switch} = sw;
		t.force_reading = 16'(frc);
		t.stretch_valid = sv;
		t.stretch_sample = 16'(smp);
		t.joy_valid = jv;
		t.manual_button = man;
		t.auto_button = aut;
		return t;
	endfunction

	// random tick; until the finish is allowed, a tick that would complete the grasp is redrawn
	function automatic cgs_item_t pick_tick(input bit allow_done);
		cgs_item_t t;
		seq_state_t trial;
		cgs_result_t r;
		logic [63:0] rnd;
		for (int tries = 0; tries < 16; tries++) begin
			rnd = {$urandom, $urandom};
			t = rnd[$bits(cgs_item_t)-1:0];
			if ($urandom_range(99) >= 10) begin
				if ($urandom_range(9) != 0) t.ctrl_mode = sb.cfg.active_mode;
				t.at_top = allow_done && ($urandom_range(5) == 0);
				t.at_bottom = ($urandom_range(2) == 0);
				t.fully_open = ($urandom_range(2) == 0);
				t.fully_closed = ($urandom_range(2) == 0);
				t.plate_switch = ($urandom_range(3) == 0);
				t.stretch_valid = ($urandom_range(2) != 0);
				case ($urandom_range(2))
					0: t.stretch_sample = 16'($urandom);
					1: t.stretch_sample = 16'(sb.cfg.stretch_limit + $urandom_range(4) - 2);
					default: t.stretch_sample = 16'($urandom_range(255));
				endcase
				if ($urandom_range(1) != 0)
					t.force_reading = 16'(sb.cfg.force_limit + $urandom_range(4) - 2);
				t.joy_valid = ($urandom_range(3) == 0);
				t.manual_button = ($urandom_range(4) == 0);
				t.auto_button = ($urandom_range(3) != 0);
			end
			trial = sb.st;
			void'(sb.advance_grasp(trial, sb.cfg, t, r));
			if (allow_done || trial.ph < PH_RAISE) return t;
		end
		t.ctrl_mode = ~sb.cfg.active_mode;
		return t;
	endfunction

	task automatic run_phase(input int n, input int send_pct, input int stall_v,
			input bit allow_done);
		send_idle_pct = send_pct;
		stall_pct = stall_v;
		for (int i = 0; i < n; i++) send_tick(pick_tick(allow_done));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	initial begin
		cgs_item_t t;
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		program_regs(3, 800, 4352, 128, 128, 30);
		// field extremes outside the active mode, then lowering under the manual deadman
		send_tick(tick_of(-128, 5'b00000, -32768, 1, 16'hFFFF, 1, 1, 1));
		send_tick(tick_of(3, 5'b00000, 0, 0, 0, 0, 0, 0));
		send_tick(tick_of(127, 5'b11111, 32767, 1, 0, 1, 0, 1));
		send_tick(tick_of(3, 5'b01000, 0, 1, 0, 0, 0, 0));
		// flush the large sample out of the stretch window
		send_tick(tick_of(-1, 5'b10101, 12345, 1, 0, 1, 0, 1));
		send_tick(tick_of(2, 5'b01010, -1, 1, 0, 0, 0, 0));
		send_tick(tick_of(4, 5'b00000, 1, 1, 0, 0, 0, 0));
		send_tick(tick_of(3, 5'b00100, 799, 0, 0, 0, 0, 0));
		// average exactly at the threshold does not count
		send_tick(tick_of(3, 5'b00000, 0, 1, int'(RstStretchLimit) * 5, 0, 0, 0));
		send_tick(tick_of(3, 5'b00001, 799, 0, 0, 0, 0, 0));
		send_tick(tick_of(3, 5'b00010, 800, 0, 0, 0, 0, 0));
		send_tick(tick_of(3, 5'b00000, -32768, 0, 0, 1, 0, 0));
		send_tick(tick_of(3, 5'b11110, 32767, 0, 0, 1, 1, 0));
		// broken grasp back to opening
		send_tick(tick_of(3, 5'b00010, 0, 0, 0, 1, 0, 1));
		// open, wait and close in one tick
		send_tick(tick_of(3, 5'b01101, 0, 0, 0, 0, 0, 0));
		send_tick(tick_of(3, 5'b00010, 100, 1, 0, 0, 0, 0));
		send_tick(tick_of(3, 5'b00100, 0, 0, 0, 0, 0, 0));
		send_tick(tick_of(3, 5'b00000, 0, 1, 1, 0, 0, 0));
		run_phase(160, 0, 0, 1'b0);
		settle();

		program_regs(-128, 100, 2000, 511, 256, 1);
		run_phase(160, 72, 0, 1'b0);
		settle();

		program_regs(127, 32767, 65535, 0, 300, 65535);
		run_phase(160, 0, 72, 1'b0);
		settle();

		// stretch without joystick messages: idle count runs past the timeout
		set_reg(REG_TIMEOUT_TICKS, 20);
		send_idle_pct = 0;
		stall_pct = 0;
		t = pick_tick(1'b0);
		t.joy_valid = 1'b1;
		t.manual_button = 1'b0;
		t.auto_button = 1'b1;
		send_tick(t);
		for (int k = 0; k < 40; k++) begin
			t = pick_tick(1'b0);
			t.joy_valid = 1'b0;
			if ((k % 4) != 0) t.ctrl_mode = ~sb.cfg.active_mode;
			send_tick(t);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		settle();

		program_regs(0, 500, 0, 200, 64, 0);
		run_phase(100, 35, 35, 1'b0);
		settle();

		program_regs(3, -32768, 4352, 256, 0, 30);
		run_phase(180, 35, 35, 1'b1);
		settle();

		if (sb.errors == 0 && sb.due_commands.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
